FILE: hw/rtl/dhsl_pkg.sv
package dhsl_pkg;

	// Default number of fraction bits kept by the slew limiter.
	localparam int FRAC_BITS_DEF = 10;

	// Field and register widths.
	localparam int TIME_W     = 32;
	localparam int SPEED_W    = 16;
	localparam int BIAS_W     = 16;
	localparam int ALTZ_W     = 15;
	localparam int DT_W       = 16;
	localparam int RATE_W     = 10;
	localparam int HOLD_W     = 16;
	localparam int ALT_W      = 14;
	localparam int LIMIT_W    = 15;
	localparam int LIM2_W     = 2 * LIMIT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// One second is 1000 ms = 125 * 2^3; the step divides by 125 and shifts by 3.
	localparam int MS_DIV   = 125;
	localparam int MS_SHIFT = 3;
	localparam int DIV_L    = 7;
	localparam int PROD_W   = RATE_W + DT_W;
	localparam int QUO_W    = PROD_W - DIV_L + 1;

	// Register values after reset.
	localparam logic [RATE_W-1:0]  RST_SLEW_RATE  = 10'd50;
	localparam logic [HOLD_W-1:0]  RST_HOLD_TIME  = 16'd3000;
	localparam logic [ALT_W-1:0]   RST_ALT_LOW    = 14'd50;
	localparam logic [ALT_W-1:0]   RST_ALT_HIGH   = 14'd300;
	localparam logic [LIMIT_W-1:0] RST_BIAS_LIMIT = 15'd200;
	localparam logic [LIM2_W-1:0]  RST_LIM2       = 30'd40000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLEW_RATE  = 3'd0,
		CFG_HOLD_TIME  = 3'd1,
		CFG_ALT_LOW    = 3'd2,
		CFG_ALT_HIGH   = 3'd3,
		CFG_BIAS_LIMIT = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [RATE_W-1:0] slew_rate;
		logic [HOLD_W-1:0] hold_time;
		logic [ALT_W-1:0]  alt_low;
		logic [ALT_W-1:0]  alt_high;
		logic [LIM2_W-1:0] lim2;
	} cfg_t;

	// Stage load enables and the state update strobe of the pipeline.
	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
		logic ld5;
		logic ld6;
		logic upd;
	} pipe_ld_t;

endpackage

FILE: hw/rtl/dhsl_cfg.sv
module dhsl_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [dhsl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dhsl_pkg::CFG_DATA_W-1:0]    cfg_data,
	output dhsl_pkg::cfg_t                     cfg
);
	import dhsl_pkg::*;

	logic [RATE_W-1:0]  slew_rate_q;
	logic [HOLD_W-1:0]  hold_time_q;
	logic [ALT_W-1:0]   alt_low_q;
	logic [ALT_W-1:0]   alt_high_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [LIM2_W-1:0]  lim2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_rate_q <= RST_SLEW_RATE;
			hold_time_q <= RST_HOLD_TIME;
			alt_low_q   <= RST_ALT_LOW;
			alt_high_q  <= RST_ALT_HIGH;
			limit_q     <= RST_BIAS_LIMIT;
			lim2_q      <= RST_LIM2;
		end else begin
			// The squared limit is registered and follows the limit in the next cycle.
			lim2_q <= LIM2_W'(limit_q) * LIM2_W'(limit_q);
			if (cfg_valid) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SLEW_RATE:  slew_rate_q <= cfg_data[RATE_W-1:0];
					CFG_HOLD_TIME:  hold_time_q <= cfg_data[HOLD_W-1:0];
					CFG_ALT_LOW:    alt_low_q   <= cfg_data[ALT_W-1:0];
					CFG_ALT_HIGH:   alt_high_q  <= cfg_data[ALT_W-1:0];
					CFG_BIAS_LIMIT: limit_q     <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign cfg.slew_rate = slew_rate_q;
	assign cfg.hold_time = hold_time_q;
	assign cfg.alt_low   = alt_low_q;
	assign cfg.alt_high  = alt_high_q;
	assign cfg.lim2      = lim2_q;

endmodule

FILE: hw/rtl/dhsl_step.sv
module dhsl_step #(
	parameter int FRAC_BITS = dhsl_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  dhsl_pkg::pipe_ld_t                    ld,
	input  logic [dhsl_pkg::RATE_W-1:0]           slew_rate,
	input  logic [dhsl_pkg::DT_W-1:0]             dt_s1,
	output logic [dhsl_pkg::QUO_W+FRAC_BITS-dhsl_pkg::MS_SHIFT-1:0] step_s5
);
	import dhsl_pkg::*;

	localparam int FR_SH   = FRAC_BITS - MS_SHIFT;
	// Integer part of rate*dt/125 by reciprocal multiplication, exact for PROD_W bits.
	localparam int SH1     = PROD_W + DIV_L;
	localparam int M1_W    = PROD_W + 1;
	localparam logic [M1_W-1:0] M1 =
		M1_W'(((64'd1 << SH1) + 64'(MS_DIV - 1)) / 64'(MS_DIV));
	localparam int MUL1_W  = PROD_W + M1_W;
	// Fraction part: remainder scaled by 2^FR_SH, divided by 125 the same way.
	localparam int N2      = DIV_L + FR_SH;
	localparam int SH2     = N2 + DIV_L;
	localparam int M2_W    = N2 + 1;
	localparam logic [M2_W-1:0] M2 =
		M2_W'(((64'd1 << SH2) + 64'(MS_DIV - 1)) / 64'(MS_DIV));
	localparam int MUL2_W  = N2 + M2_W;

	logic [PROD_W-1:0] p_d, p_s2, p_s3;
	logic [MUL1_W-1:0] mul1;
	logic [QUO_W-1:0]  a_s3, a_s4;
	logic [PROD_W-1:0] rem_full;
	logic [N2-1:0]     rs_d, rs_s4;
	logic [MUL2_W-1:0] mul2;
	logic [FR_SH-1:0]  frac;

	assign p_d      = PROD_W'(slew_rate) * PROD_W'(dt_s1);
	assign mul1     = MUL1_W'(p_s2) * MUL1_W'(M1);
	assign rem_full = p_s3 - PROD_W'(a_s3) * PROD_W'(MS_DIV);
	assign rs_d     = {rem_full[DIV_L-1:0], {FR_SH{1'b0}}};
	assign mul2     = MUL2_W'(rs_s4) * MUL2_W'(M2);
	assign frac     = mul2[SH2 +: FR_SH];

	always_ff @(posedge clk) begin
		if (ld.ld2) begin
			p_s2 <= p_d;
		end
		if (ld.ld3) begin
			p_s3 <= p_s2;
			a_s3 <= mul1[SH1 +: QUO_W];
		end
		if (ld.ld4) begin
			a_s4  <= a_s3;
			rs_s4 <= rs_d;
		end
		if (ld.ld5) begin
			step_s5 <= {a_s4, frac};
		end
	end

endmodule

FILE: hw/rtl/dhsl_update.sv
module dhsl_update #(
	parameter int FRAC_BITS = dhsl_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dhsl_pkg::pipe_ld_t                    ld,
	input  logic [dhsl_pkg::HOLD_W-1:0]           hold_time,
	input  logic [dhsl_pkg::TIME_W-1:0]           now_s5,
	input  logic signed [dhsl_pkg::SPEED_W-1:0]   cmd_s5,
	input  logic                                  clear_s5,
	input  logic                                  want_s5,
	input  logic [dhsl_pkg::QUO_W+FRAC_BITS-dhsl_pkg::MS_SHIFT-1:0] step_s5,
	output logic signed [dhsl_pkg::SPEED_W-1:0]   speed_s6,
	output logic                                  holding_s6,
	output logic                                  armed_s6
);
	import dhsl_pkg::*;

	localparam int SV_W   = SPEED_W + FRAC_BITS;
	localparam int STEP_W = QUO_W + FRAC_BITS - MS_SHIFT;
	localparam int CW     = STEP_W + 2;
	localparam logic signed [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);

	logic signed [SV_W-1:0]    slew_q, slew_d;
	logic                      active_q, permit_q;
	logic [TIME_W-1:0]         start_q;

	logic                      act0, perm0, start, ends, act2, perm2;
	logic [TIME_W-1:0]         elapsed;
	logic signed [CW-1:0]      v_ext, cmd_ext, tgt, step_ext, up, dn, up_r, dn_r;
	logic signed [SPEED_W-1:0] speed_d;

	always_comb begin
		// Clear first, then the start test, then the end test.
		act0    = clear_s5 ? 1'b0 : active_q;
		perm0   = clear_s5 | permit_q;
		start   = want_s5 & perm0 & ~act0;
		elapsed = now_s5 - start_q;
		// A hold started in this tick has zero elapsed time and cannot end.
		ends    = act0 & (elapsed > TIME_W'(hold_time));
		act2    = (act0 & ~ends) | start;
		perm2   = perm0 & ~ends;

		v_ext    = {{(CW-SV_W){slew_q[SV_W-1]}}, slew_q};
		cmd_ext  = {{(CW-SPEED_W){cmd_s5[SPEED_W-1]}}, cmd_s5};
		tgt      = act2 ? '0 : (cmd_ext <<< FRAC_BITS);
		step_ext = {2'b00, step_s5};
		up       = v_ext + step_ext;
		dn       = v_ext - step_ext;
		up_r     = v_ext + step_ext + HALF;
		dn_r     = v_ext - step_ext + HALF;

		// Rounding is taken in parallel for each choice; the new value always
		// lies between the old value and the target, so it fits the output.
		if (tgt > up) begin
			slew_d  = up[SV_W-1:0];
			speed_d = up_r[FRAC_BITS +: SPEED_W];
		end else if (tgt < dn) begin
			slew_d  = dn[SV_W-1:0];
			speed_d = dn_r[FRAC_BITS +: SPEED_W];
		end else begin
			slew_d  = tgt[SV_W-1:0];
			speed_d = act2 ? '0 : cmd_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			permit_q <= 1'b1;
			start_q  <= '0;
			slew_q   <= '0;
		end else if (ld.upd) begin
			active_q <= act2;
			permit_q <= perm2;
			if (start) begin
				start_q <= now_s5;
			end
			slew_q <= slew_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld6) begin
			speed_s6   <= speed_d;
			holding_s6 <= act2;
			armed_s6   <= perm2;
		end
	end

endmodule

FILE: hw/rtl/descent_hold_slew_limiter.sv
// Chan  Handshake            Dir  Payload
// ----  -------------------  ---  --------------------------------------------------------
// in    in_valid/in_stall    in   now_ms landing speed_cmd bias_x bias_y alt_z clear_hold
// out   out_valid/out_stall  out  speed_out holding hold_armed
// cfg   cfg_valid/cfg_ready  in   cfg_index cfg_data
//
// One tick is accepted in every cycle unless the input stalls; the result register is loaded
// once its tick has passed the five stages ahead of the update that form the slew step (rate
// times elapsed time, then two reciprocal multiplications for the division by a thousand).
// The asynchronous reset empties the pipeline, re-arms the hold and returns every
// configuration register to its default value.
// A stalled output holds the result register; the stages behind it keep moving into any
// empty stage, so the input stalls only while every stage is full and the output is stalled.
module descent_hold_slew_limiter #(
	parameter int FRAC_BITS = dhsl_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dhsl_pkg::TIME_W-1:0]         now_ms,
	input  logic                                landing,
	input  logic signed [dhsl_pkg::SPEED_W-1:0] speed_cmd,
	input  logic signed [dhsl_pkg::BIAS_W-1:0]  bias_x,
	input  logic signed [dhsl_pkg::BIAS_W-1:0]  bias_y,
	input  logic signed [dhsl_pkg::ALTZ_W-1:0]  alt_z,
	input  logic                                clear_hold,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dhsl_pkg::SPEED_W-1:0] speed_out,
	output logic                                holding,
	output logic                                hold_armed,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dhsl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dhsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dhsl_pkg::*;

	localparam int STEP_W = QUO_W + FRAC_BITS - MS_SHIFT;
	localparam int MAG_W  = 2 * BIAS_W;
	localparam int SQ_W   = MAG_W - 1;

	cfg_t     cfg;
	pipe_ld_t ld;

	// Valid bit of each stage; stage six is the result register.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic accept;

	// Time stamp of the last accepted tick, the base for the elapsed time.
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] diff;
	logic [DT_W-1:0]   dt_d;
	logic [ALTZ_W-1:0] alt_abs_d;

	logic [TIME_W-1:0]         now_s1, now_s2, now_s3, now_s4, now_s5;
	logic signed [SPEED_W-1:0] cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	logic                      clear_s1, clear_s2, clear_s3, clear_s4, clear_s5;
	logic                      landing_s1;
	logic signed [BIAS_W-1:0]  bx_s1, by_s1;
	logic [ALTZ_W-1:0]         alt_abs_s1;
	logic [DT_W-1:0]           dt_s1;
	logic                      lw_s2;
	logic [SQ_W-1:0]           sqx_s2, sqy_s2;
	logic                      want_s3, want_s4, want_s5;
	logic signed [MAG_W-1:0]   sqx_full, sqy_full;
	logic [MAG_W-1:0]          mag2;
	logic                      win_d;
	logic [STEP_W-1:0]         step_s5;

	// A stage takes a new transaction when it is empty or its content moves on.
	assign en6    = ~v_s6 | ~out_stall;
	assign en5    = ~v_s5 | en6;
	assign en4    = ~v_s4 | en5;
	assign en3    = ~v_s3 | en4;
	assign en2    = ~v_s2 | en3;
	assign en1    = ~v_s1 | en2;
	assign accept = in_valid & en1;

	assign in_stall  = ~en1;
	assign out_valid = v_s6;
	assign cfg_ready = 1'b1;

	assign ld.ld2 = en2;
	assign ld.ld3 = en3;
	assign ld.ld4 = en4;
	assign ld.ld5 = en5;
	assign ld.ld6 = en6;
	// The hold and limiter state advance once per tick, as it leaves the update stage.
	assign ld.upd = v_s5 & en6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			last_q <= '0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (accept) begin
				last_q <= now_ms;
			end
		end
	end

	// Elapsed time since the previous tick, wrapped and then saturated at 16 bits.
	assign diff      = now_ms - last_q;
	assign dt_d      = (|diff[TIME_W-1:DT_W]) ? {DT_W{1'b1}} : diff[DT_W-1:0];
	assign alt_abs_d = alt_z[ALTZ_W-1] ? ALTZ_W'(-alt_z) : ALTZ_W'(alt_z);

	// Both altitude bounds are exclusive.
	assign win_d    = (alt_abs_s1 > ALTZ_W'(cfg.alt_low)) &&
	                  (alt_abs_s1 < ALTZ_W'(cfg.alt_high));
	assign sqx_full = bx_s1 * bx_s1;
	assign sqy_full = by_s1 * by_s1;
	assign mag2     = MAG_W'(sqx_s2) + MAG_W'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en1) begin
			now_s1     <= now_ms;
			landing_s1 <= landing;
			cmd_s1     <= speed_cmd;
			bx_s1      <= bias_x;
			by_s1      <= bias_y;
			alt_abs_s1 <= alt_abs_d;
			clear_s1   <= clear_hold;
			dt_s1      <= dt_d;
		end
		if (en2) begin
			now_s2   <= now_s1;
			cmd_s2   <= cmd_s1;
			clear_s2 <= clear_s1;
			lw_s2    <= landing_s1 & win_d;
			// A square of a 16-bit signed value is never negative and fits 31 bits.
			sqx_s2   <= sqx_full[SQ_W-1:0];
			sqy_s2   <= sqy_full[SQ_W-1:0];
		end
		if (en3) begin
			now_s3   <= now_s2;
			cmd_s3   <= cmd_s2;
			clear_s3 <= clear_s2;
			want_s3  <= lw_s2 & (mag2 > MAG_W'(cfg.lim2));
		end
		if (en4) begin
			now_s4   <= now_s3;
			cmd_s4   <= cmd_s3;
			clear_s4 <= clear_s3;
			want_s4  <= want_s3;
		end
		if (en5) begin
			now_s5   <= now_s4;
			cmd_s5   <= cmd_s4;
			clear_s5 <= clear_s4;
			want_s5  <= want_s4;
		end
	end

	dhsl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dhsl_step #(
		.FRAC_BITS (FRAC_BITS)
	) u_step (
		.clk       (clk),
		.ld        (ld),
		.slew_rate (cfg.slew_rate),
		.dt_s1     (dt_s1),
		.step_s5   (step_s5)
	);

	dhsl_update #(
		.FRAC_BITS (FRAC_BITS)
	) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (ld),
		.hold_time  (cfg.hold_time),
		.now_s5     (now_s5),
		.cmd_s5     (cmd_s5),
		.clear_s5   (clear_s5),
		.want_s5    (want_s5),
		.step_s5    (step_s5),
		.speed_s6   (speed_out),
		.holding_s6 (holding),
		.armed_s6   (hold_armed)
	);

endmodule
